// ===== hdl/scaled_seven_segment_text_renderer_unit_macros.svh =====
// Assertion helpers used by the renderer back end (sssr_back).
// Both expect clk and rst_n in scope.
`ifndef SCALED_SEVEN_SEGMENT_TEXT_RENDERER_UNIT_MACROS_SVH
`define SCALED_SEVEN_SEGMENT_TEXT_RENDERER_UNIT_MACROS_SVH

// same-cycle implication
`define SSSR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sssr check failed");

// next-cycle implication
`define SSSR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sssr check failed");

`endif

// ===== hdl/sssr_pkg.sv =====
package sssr_pkg;

  localparam int SCALE_W = 4;
  localparam int NUM_W   = 27;
  localparam int GLYPH_W = 2;

  localparam int QUEUE_DEPTH = 2;  // power of two

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE    = 2'd0;
  localparam logic [GLYPH_W-1:0] GLYPH_HSTROKE  = 2'd1;
  localparam logic [GLYPH_W-1:0] GLYPH_VSTROKE  = 2'd2;
  localparam logic [GLYPH_W-1:0] GLYPH_LINE_END = 2'd3;

  // bit positions in a segment pattern
  localparam int SEG_A = 0;
  localparam int SEG_B = 1;
  localparam int SEG_C = 2;
  localparam int SEG_D = 3;
  localparam int SEG_E = 4;
  localparam int SEG_F = 5;
  localparam int SEG_G = 6;

  typedef struct packed {
    logic               command;
    logic [SCALE_W-1:0] scale;
    logic [NUM_W-1:0]   number;
  } in_req_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               frame_last;
  } out_res_t;

  // classified request as held in the queue
  typedef struct packed {
    logic               is_load;
    logic [SCALE_W-1:0] scale;
    logic [NUM_W-1:0]   number;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_CONV,
    BK_FIN
  } back_state_t;

  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/sssr_front.sv =====
module sssr_front #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_SCALE  = 15
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  sssr_pkg::in_req_t in_req,
  input  logic              q_full,
  output sssr_pkg::q_push_t q_push
);
  import sssr_pkg::*;

  localparam longint unsigned DEC_LIMIT = longint'(10 ** MAX_DIGITS) - 1;

  logic [SCALE_W-1:0] scale_sat;
  logic [NUM_W-1:0]   number_sat;

  assign in_ready = !q_full;

  always_comb begin
    if (in_req.scale == '0) begin
      scale_sat = SCALE_W'(1);
    end else if (int'(in_req.scale) > MAX_SCALE) begin
      scale_sat = SCALE_W'(MAX_SCALE);
    end else begin
      scale_sat = in_req.scale;
    end
  end

  // too many digits: clamp to all nines
  always_comb begin
    if (64'(in_req.number) > DEC_LIMIT) begin
      number_sat = NUM_W'(DEC_LIMIT);
    end else begin
      number_sat = in_req.number;
    end
  end

  always_comb begin
    q_push.push          = in_valid && in_ready;
    q_push.entry.is_load = (in_req.command == CMD_LOAD);
    q_push.entry.scale   = scale_sat;
    q_push.entry.number  = number_sat;
  end

endmodule

// ===== hdl/sssr_queue.sv =====
module sssr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sssr_pkg::q_push_t q_push,
  output logic              q_full,
  input  logic              q_pop,
  output sssr_pkg::q_head_t q_head
);
  import sssr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign q_full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.entry = mem[rd_ptr_r];

  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && q_head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/sssr_back.sv =====
`include "scaled_seven_segment_text_renderer_unit_macros.svh"

module sssr_back #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_SCALE  = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sssr_pkg::q_head_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sssr_pkg::out_res_t out_res
);
  import sssr_pkg::*;

  localparam int SW     = $clog2(MAX_SCALE + 1);
  localparam int RW     = $clog2(2 * MAX_SCALE + 4);
  localparam int CW     = $clog2(MAX_SCALE + 3);
  localparam int DPW    = $clog2(MAX_DIGITS + 1);
  localparam int IW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BCNT_W = $clog2(NUM_W + 1);

  back_state_t       state_r, state_nxt;
  logic [SW-1:0]     scale_r, scale_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [DPW-1:0]    dpos_r, dpos_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [DPW-1:0]    cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [BCNT_W-1:0] bit_r, bit_nxt;
  logic [NUM_W-1:0]  bin_r, bin_nxt;
  logic [3:0]        bcd_r   [MAX_DIGITS];
  logic [3:0]        bcd_nxt [MAX_DIGITS];
  logic [3:0]        bcd_adj [MAX_DIGITS];
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic              out_free, emit;
  out_res_t          emit_res;
  logic [DPW-1:0]    used_digits;
  logic [IW-1:0]     dig_sel;
  logic [6:0]        seg;
  logic [RW-1:0]     row_mid, row_bot, row_end;
  logic [CW-1:0]     col_right;
  logic              horiz, at_side, upper, hseg;
  logic [GLYPH_W-1:0] cell_glyph;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = !out_valid_r || out_ready;

  // row landmarks: middle stroke, bottom stroke, closing line
  assign row_mid   = RW'(scale_r) + RW'(1);
  assign row_bot   = row_mid + RW'(scale_r) + RW'(1);
  assign row_end   = row_bot + RW'(1);
  assign col_right = CW'(scale_r) + CW'(2);

  // digits sit least significant first in the BCD register
  assign dig_sel = IW'(cnt_r - DPW'(1) - dpos_r);
  assign seg     = seg_pattern(bcd_r[dig_sel]);

  always_comb begin
    horiz   = (row_r == '0) || (row_r == row_mid) || (row_r == row_bot);
    at_side = (col_r == CW'(1)) || (col_r >= col_right);
    upper   = (row_r < row_mid);
    if (row_r == '0) begin
      hseg = seg[SEG_A];
    end else if (row_r == row_mid) begin
      hseg = seg[SEG_G];
    end else begin
      hseg = seg[SEG_D];
    end
    cell_glyph = GLYPH_SPACE;
    if (horiz) begin
      if (!at_side && hseg) begin
        cell_glyph = GLYPH_HSTROKE;
      end
    end else if (col_r == CW'(1)) begin
      if (upper ? seg[SEG_F] : seg[SEG_E]) begin
        cell_glyph = GLYPH_VSTROKE;
      end
    end else if (col_r >= col_right) begin
      if (upper ? seg[SEG_B] : seg[SEG_C]) begin
        cell_glyph = GLYPH_VSTROKE;
      end
    end
  end

  // double dabble: add 3 to each digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_comb begin
    used_digits = DPW'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        used_digits = DPW'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    scale_nxt = scale_r;
    row_nxt   = row_r;
    dpos_nxt  = dpos_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    bit_nxt   = bit_r;
    bin_nxt   = bin_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_nxt[i] = bcd_r[i];
    end
    q_pop               = 1'b0;
    emit                = 1'b0;
    emit_res.glyph      = GLYPH_SPACE;
    emit_res.frame_last = 1'b0;

    unique case (state_r)
      BK_RUN: begin
        if (q_head.valid) begin
          if (q_head.entry.is_load) begin
            q_pop     = 1'b1;
            scale_nxt = SW'(q_head.entry.scale);
            bin_nxt   = q_head.entry.number;
            bit_nxt   = '0;
            pend_nxt  = 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
              bcd_nxt[i] = 4'd0;
            end
            state_nxt = BK_CONV;
          end else if (!pend_r) begin
            q_pop = 1'b1;  // nothing to draw, drop the request
          end else if (out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            if (row_r >= row_end) begin
              emit_res.glyph      = GLYPH_LINE_END;
              emit_res.frame_last = 1'b1;
              pend_nxt            = 1'b0;
            end else if (dpos_r >= cnt_r) begin
              emit_res.glyph = GLYPH_LINE_END;
              row_nxt        = row_r + RW'(1);
              dpos_nxt       = '0;
              col_nxt        = CW'(1);
            end else if (col_r == '0) begin
              emit_res.glyph = GLYPH_SPACE;  // gap between digits
              col_nxt        = CW'(1);
            end else begin
              emit_res.glyph = cell_glyph;
              if (col_r >= col_right) begin
                dpos_nxt = dpos_r + DPW'(1);
                col_nxt  = '0;
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
          end
        end
      end
      BK_CONV: begin
        bin_nxt    = {bin_r[NUM_W-2:0], 1'b0};
        bcd_nxt[0] = {bcd_adj[0][2:0], bin_r[NUM_W-1]};
        for (int i = 1; i < MAX_DIGITS; i++) begin
          bcd_nxt[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
        end
        bit_nxt = bit_r + BCNT_W'(1);
        if (bit_r == BCNT_W'(NUM_W - 1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        cnt_nxt   = used_digits;
        row_nxt   = '0;
        dpos_nxt  = '0;
        col_nxt   = CW'(1);
        pend_nxt  = 1'b1;
        state_nxt = BK_RUN;
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase

    out_valid_nxt = emit || (out_valid_r && !out_ready);
    out_res_nxt   = emit ? emit_res : out_res_r;
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    out_res_r <= out_res_nxt;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_r[i] <= bcd_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      scale_r     <= SW'(1);
      row_r       <= '0;
      dpos_r      <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      row_r       <= row_nxt;
      dpos_r      <= dpos_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SSSR_ASSERT_NXT(a_load_starts_conv, state_r == BK_RUN && q_head.valid && q_head.entry.is_load, state_r == BK_CONV)
  `SSSR_ASSERT_IMP(a_digit_pos_range, pend_r, dpos_r <= cnt_r && cnt_r != '0)
  `SSSR_ASSERT_IMP(a_col_range, pend_r, col_r <= col_right)
  `SSSR_ASSERT_NXT(a_last_ends_frame, emit && emit_res.frame_last, !pend_r && out_valid_r)

endmodule

// ===== hdl/scaled_seven_segment_text_renderer_unit.sv =====
// Step request: queued, then registered at the output; one glyph per cycle
// sustained while out_ready is high and steps are queued, set by the raster counters.
// Load request: the back end converts all NUM_W bits from binary to BCD
// (one bit per cycle); the 2-entry request queue keeps accepting meanwhile until full.
// Reset (rst_n low, synchronous): no frame pending, scale one, queue and output empty.
module scaled_seven_segment_text_renderer_unit #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_SCALE  = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sssr_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output sssr_pkg::out_res_t out_res
);
  import sssr_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  sssr_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  sssr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  sssr_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

// ===== test/scaled_seven_segment_text_renderer_unit_tb.sv =====
module scaled_seven_segment_text_renderer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sssr_pkg::*;

  localparam int          MAX_DIGITS  = 8;
  localparam int          MAX_SCALE   = 15;
  localparam int unsigned ALL_NINES   = 99999999;
  localparam int          LONG_HOLD   = 300;
  localparam int          DRAIN_WAIT  = 60;
  localparam int          STIM_ITEMS  = 900;

  // segment masks for decimal digits, bit order a..g from bit 0
  localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_res;

  scaled_seven_segment_text_renderer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  in_req_t  queued_commands [$];
  out_res_t expected_glyphs [$];
  int       mismatches = 0;

  // raster state mirrored from the block
  logic [3:0]  shown_digits [MAX_DIGITS];
  int unsigned shown_count = 0;
  int unsigned shown_scale = 1;
  int unsigned row_at = 0;
  int unsigned digit_at = 0;
  int unsigned col_at = 0;
  bit          frame_open = 1'b0;

  function automatic logic [1:0] cell_glyph(input logic [3:0] digit, input int unsigned s,
                                            input int unsigned r, input int unsigned c);
    logic [6:0] segs;
    bit         rim;
    int         seg_bit;
    segs = DIGIT_SEGMENTS[digit];
    rim = (c == 0) || (c == s + 1);
    if (r == 0 || r == s + 1 || r == 2 * s + 2) begin
      seg_bit = (r == 0) ? SEG_A : (r == s + 1) ? SEG_G : SEG_D;
      if (!rim && segs[seg_bit])
        return GLYPH_HSTROKE;
      return GLYPH_SPACE;
    end
    if (c == 0)
      return segs[(r <= s) ? SEG_F : SEG_E] ? GLYPH_VSTROKE : GLYPH_SPACE;
    if (c == s + 1)
      return segs[(r <= s) ? SEG_B : SEG_C] ? GLYPH_VSTROKE : GLYPH_SPACE;
    return GLYPH_SPACE;
  endfunction

  task automatic predict_glyph(input in_req_t req);
    int unsigned n;
    int unsigned k;
    int unsigned c;
    int          i;
    logic [3:0]  low_first [MAX_DIGITS];
    out_res_t    res;
    if (req.command == CMD_LOAD) begin
      n = 32'(req.number);
      if (n > ALL_NINES)
        n = ALL_NINES;
      k = 0;
      do begin
        low_first[k] = 4'(n % 10);
        n = n / 10;
        k++;
      end while (n != 0 && k < MAX_DIGITS);
      for (i = 0; i < k; i++)
        shown_digits[i] = low_first[k - 1 - i];
      shown_count = k;
      shown_scale = (req.scale == 0) ? 1 :
                    (int'(req.scale) > MAX_SCALE) ? MAX_SCALE : int'(req.scale);
      row_at = 0;
      digit_at = 0;
      col_at = 1;
      frame_open = 1'b1;
    end else if (frame_open) begin
      res.frame_last = 1'b0;
      if (row_at >= 2 * shown_scale + 3) begin
        res.glyph = GLYPH_LINE_END;
        res.frame_last = 1'b1;
        frame_open = 1'b0;
      end else if (digit_at >= shown_count) begin
        res.glyph = GLYPH_LINE_END;
        row_at++;
        digit_at = 0;
        col_at = 1;
      end else if (col_at == 0) begin
        res.glyph = GLYPH_SPACE;
        col_at = 1;
      end else begin
        c = col_at - 1;
        res.glyph = cell_glyph(shown_digits[digit_at], shown_scale, row_at, c);
        if (c >= shown_scale + 1) begin
          digit_at++;
          col_at = 0;
        end else begin
          col_at++;
        end
      end
      expected_glyphs.push_back(res);
    end
  endtask

  // driver
  int unsigned sent_reqs = 0;
  bit          send_steady;

  assign send_steady = (sent_reqs >= 400) && (sent_reqs < 600);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_glyph(in_req);
        sent_reqs++;
      end
      if (!in_valid || in_ready) begin
        if (queued_commands.size() != 0 && (send_steady || $urandom_range(99) >= 18)) begin
          in_req <= queued_commands.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver back-pressure
  int unsigned glyphs_seen = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  out_res_t    want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        glyphs_seen++;
        if (expected_glyphs.size() == 0) begin
          $error("unexpected result: glyph=%0d frame_last=%0d", out_res.glyph,
                 out_res.frame_last);
          mismatches++;
        end else begin
          want = expected_glyphs.pop_front();
          if (out_res.glyph !== want.glyph) begin
            $error("glyph: expected %0d, got %0d", want.glyph, out_res.glyph);
            mismatches++;
          end
          if (out_res.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, out_res.frame_last);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && glyphs_seen >= 150) begin
        // long stall so the request queue backs up
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (glyphs_seen >= 500 && glyphs_seen < 750) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic queue_cmd(input logic command, input logic [3:0] scale,
                           input logic [26:0] number);
    in_req_t req;
    req.command = command;
    req.scale = scale;
    req.number = number;
    queued_commands.push_back(req);
  endtask

  task automatic queue_steps(input int count);
    int i;
    for (i = 0; i < count; i++)
      queue_cmd(CMD_STEP, 4'($urandom), 27'($urandom));
  endtask

  function automatic int frame_length(input logic [3:0] scale, input logic [26:0] number);
    int unsigned n;
    int          s;
    int          digits;
    n = (number > ALL_NINES) ? ALL_NINES : 32'(number);
    s = (scale == 0) ? 1 : int'(scale);
    digits = 1;
    while (n >= 10) begin
      n = n / 10;
      digits++;
    end
    return (2 * s + 3) * (digits * (s + 2) + digits) + 1;
  endfunction

  function automatic logic [26:0] pick_number();
    int pick;
    int width;
    pick = $urandom_range(99);
    if (pick < 65) begin
      width = $urandom_range(1, 3);
      return 27'($urandom_range(0, (10 ** width) - 1));
    end
    if (pick < 82)
      return 27'($urandom);
    case ($urandom_range(5))
      0:       return 27'd0;
      1:       return 27'd9;
      2:       return 27'd10000000;
      3:       return 27'd99999999;
      4:       return 27'd100000000;
      default: return '1;
    endcase
  endfunction

  initial begin
    int          stim_items;
    int          len;
    int          steps;
    bit          big_done;
    logic [3:0]  scale;
    logic [26:0] number;

    // directed: idle step, smallest frame end to end, saturation, frame dropped by load
    queue_steps(1);
    queue_cmd(CMD_LOAD, 4'd0, 27'd0);
    queue_steps(frame_length(4'd0, 27'd0) + 1);
    queue_cmd(CMD_LOAD, 4'd15, '1);
    queue_steps(2);
    queue_cmd(CMD_LOAD, 4'd1, 27'd100000000);
    queue_steps(1);

    stim_items = 0;
    big_done = 1'b0;
    while (stim_items < STIM_ITEMS) begin
      scale = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      number = pick_number();
      queue_cmd(CMD_LOAD, scale, number);
      stim_items++;
      if ($urandom_range(99) < 5)
        continue;
      len = frame_length(scale, number);
      if (len <= 250 || (!big_done && len <= 1200 && stim_items < STIM_ITEMS / 2)) begin
        steps = len;
        if (len > 250)
          big_done = 1'b1;
      end else begin
        steps = $urandom_range(20, 250);
      end
      if ($urandom_range(99) < 12)
        steps = $urandom_range(1, steps);
      queue_steps(steps);
      stim_items += steps;
      if (steps == len)
        queue_steps($urandom_range(0, 2));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_commands.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_glyphs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_glyphs.size() != 0) begin
      $error("%0d expected results never arrived", expected_glyphs.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[scaled_seven_segment_text_renderer_unit] OK");
    end else begin
      $display("[scaled_seven_segment_text_renderer_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("[scaled_seven_segment_text_renderer_unit] ERROR");
    $finish;
  end

endmodule
